[hdl/gaussian_integer_classifier_core_defines.svh]
// Assertion macros shared by the checker files of the classifier.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef GAUSSIAN_INTEGER_CLASSIFIER_CORE_DEFINES_SVH
`define GAUSSIAN_INTEGER_CLASSIFIER_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define GIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[hdl/gic_pkg.sv]
package gic_pkg;

    // Result class codes.
    localparam logic [1:0] CLASS_ZERO      = 2'd0;
    localparam logic [1:0] CLASS_UNIT      = 2'd1;
    localparam logic [1:0] CLASS_PRIME     = 2'd2;
    localparam logic [1:0] CLASS_COMPOSITE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture magnitudes of a new beat
        logic square;     // register both squares
        logic sum;        // form norm and trial candidate
        logic init_div;   // first trial divisor is three
        logic start_div;  // begin one remainder computation
        logic div_step;   // one shift-subtract step
        logic next_div;   // advance to the next odd divisor
    } gic_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic norm_zero;
        logic norm_one;
        logic axis_bad;   // on an axis and not 3 mod 4
        logic cand_two;
        logic cand_even;
        logic sq_over;    // divisor squared exceeds the candidate
        logic div_last;   // last shift-subtract step of this divisor
        logic rem_zero;
    } gic_stat_t;

endpackage

[hdl/gic_ctrl.sv]
module gic_ctrl
    import gic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] class_code,
    output gic_cmd_t   cmd,
    input  gic_stat_t  stat
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SQUARE   = 8'b0000_0010,
        S_NORM     = 8'b0000_0100,
        S_CLASSIFY = 8'b0000_1000,
        S_CHECK    = 8'b0001_0000,
        S_DIVIDE   = 8'b0010_0000,
        S_TEST     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       result_valid_reg, result_valid_next;
    logic [1:0] result_code_reg, result_code_next;
    logic       done;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        done       = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_CLASSIFY;
            end
            S_CLASSIFY:
            begin
                priority if (stat.norm_zero)
                begin
                    code_next  = CLASS_ZERO;
                    state_next = S_DONE;
                end
                else if (stat.norm_one)
                begin
                    code_next  = CLASS_UNIT;
                    state_next = S_DONE;
                end
                else if (stat.axis_bad)
                begin
                    code_next  = CLASS_COMPOSITE;
                    state_next = S_DONE;
                end
                else if (stat.cand_two)
                begin
                    code_next  = CLASS_PRIME;
                    state_next = S_DONE;
                end
                else if (stat.cand_even)
                begin
                    code_next  = CLASS_COMPOSITE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.init_div = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.sq_over)
                begin
                    code_next  = CLASS_PRIME;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (stat.rem_zero)
                begin
                    code_next  = CLASS_COMPOSITE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register frees the worker as soon as a result is parked.
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_code_next  = result_code_reg;
        if (done)
        begin
            result_valid_next = 1'b1;
            result_code_next  = code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg        <= code_next;
        result_code_reg <= result_code_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign class_code   = result_code_reg;

endmodule

[hdl/gic_dp.sv]
module gic_dp
    import gic_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  gic_cmd_t                      cmd,
    input  logic signed [COORD_WIDTH-1:0] real_value,
    input  logic signed [COORD_WIDTH-1:0] imag_value,
    output gic_stat_t                     stat
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * COORD_WIDTH;
    localparam int CW = $clog2(NW);

    logic [W-1:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic [NW-1:0] sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic [NW-1:0] norm_reg, norm_next, cand_reg, cand_next;
    logic          axis_reg, axis_next;
    logic [W-1:0]  div_reg, div_next;
    logic [NW-1:0] sq_reg, sq_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [NW-1:0] shift_reg, shift_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W-1:0]  real_mag, imag_mag;
    logic [W:0]    trial, trial_diff;
    logic          trial_ge;
    logic [W+1:0]  sq_step;

    // Magnitude of a two's complement part; the most negative code maps to 2^(W-1).
    assign real_mag = real_value[W-1] ? (~real_value + W'(1)) : real_value;
    assign imag_mag = imag_value[W-1] ? (~imag_value + W'(1)) : imag_value;

    // One restoring step of the remainder computation.
    assign trial      = {rem_reg, shift_reg[NW-1]};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign trial_diff = trial - {1'b0, div_reg};

    // (d+2)^2 - d^2 = 4d + 4
    assign sq_step = {div_reg, 2'b00} + (W+2)'(4);

    always_comb
    begin
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        norm_next  = norm_reg;
        cand_next  = cand_reg;
        axis_next  = axis_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            ma_next = real_mag;
            mb_next = imag_mag;
        end
        if (cmd.square)
        begin
            sqa_next = NW'(ma_reg) * NW'(ma_reg);
            sqb_next = NW'(mb_reg) * NW'(mb_reg);
        end
        if (cmd.sum)
        begin
            norm_next = sqa_reg + sqb_reg;
            axis_next = (ma_reg == '0) || (mb_reg == '0);
            // On an axis one part is zero, so the OR equals the sum.
            cand_next = axis_next ? NW'(ma_reg | mb_reg) : (sqa_reg + sqb_reg);
        end
        if (cmd.init_div)
        begin
            div_next = W'(3);
            sq_next  = NW'(9);
        end
        if (cmd.start_div)
        begin
            rem_next   = '0;
            shift_next = cand_reg;
            cnt_next   = '0;
        end
        if (cmd.div_step)
        begin
            rem_next   = trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
            shift_next = {shift_reg[NW-2:0], 1'b0};
            cnt_next   = cnt_reg + CW'(1);
        end
        if (cmd.next_div)
        begin
            div_next = div_reg + W'(2);
            sq_next  = sq_reg + NW'(sq_step);
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        sqa_reg   <= sqa_next;
        sqb_reg   <= sqb_next;
        norm_reg  <= norm_next;
        cand_reg  <= cand_next;
        axis_reg  <= axis_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
    end

    always_comb
    begin
        stat.norm_zero = (norm_reg == '0);
        stat.norm_one  = (norm_reg == NW'(1));
        stat.axis_bad  = axis_reg && (cand_reg[1:0] != 2'b11);
        stat.cand_two  = (cand_reg == NW'(2));
        stat.cand_even = !cand_reg[0];
        stat.sq_over   = (sq_reg > cand_reg);
        stat.div_last  = (cnt_reg == CW'(NW - 1));
        stat.rem_zero  = (rem_reg == '0);
    end

endmodule

[hdl/gaussian_integer_classifier_core.sv]
// Channel   Handshake                  Payload
// input     item_valid / item_stall    real_value, imag_value (COORD_WIDTH, signed)
// output    result_valid / result_stall class_code (2 bits)
//
// An input beat is taken only while the block is idle; each beat gives exactly one result.
// Zero, unit and most composites on an axis or of even norm are settled in S_CLASSIFY after
// the squares and the norm, and the block is idle again once the result is parked.
// Otherwise each odd trial divisor takes one bound check, one remainder bit per cycle through
// the shift-subtract unit and one zero test, for up to about 2^(COORD_WIDTH-1.5) divisors
// in the worst case.
// rst_n clears the controller and the output valid asynchronously; no clearing pass.
// A stalled result sits in the output register while the next beat is already accepted.
module gaussian_integer_classifier_core
    import gic_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [COORD_WIDTH-1:0] real_value,
    input  logic signed [COORD_WIDTH-1:0] imag_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    class_code
);

    // Commands flow from the sequencer into the arithmetic; status flows back.
    gic_cmd_t  cmd;
    gic_stat_t stat;

    // The controller walks the classification: squares, norm, the quick cases,
    // and then the trial-division loop, and it owns the output register.
    gic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .class_code   (class_code),
        .cmd          (cmd),
        .stat         (stat)
    );

    // The datapath holds magnitudes, the norm, the candidate being tested, the
    // current odd divisor with its square, and the bit-serial remainder unit.
    gic_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .real_value (real_value),
        .imag_value (imag_value),
        .stat       (stat)
    );

endmodule

[hdl/gic_checker.sv]
`include "gaussian_integer_classifier_core_defines.svh"

module gic_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] class_code
);

    logic       item_beat, result_beat;
    logic [1:0] pend_reg, pend_next;

    assign item_beat   = item_valid && !item_stall;
    assign result_beat = result_valid && !result_stall;

    // Beats taken in but not yet delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if (item_beat && !result_beat)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!item_beat && result_beat)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `GIC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(class_code))
    `GIC_ASSERT_NEXT(a_busy_after_beat, item_beat, item_stall)
    `GIC_ASSERT_SAME(a_no_orphan_result, result_valid, pend_reg != 2'd0)
    `GIC_ASSERT_SAME(a_pend_bound, 1'b1, pend_reg != 2'd3)

endmodule

bind gaussian_integer_classifier_core gic_checker u_checker (.*);
